[rtl/mx4au_pkg.sv]
// shared types and constants of the 4x4 matrix arithmetic unit
package mx4au_pkg;

  // fraction bits of the Q16.16 format
  localparam int FRAC_BITS = 16;

  // width of the scalar register
  localparam int SCALE_WIDTH = 32;

  // operation codes of op_mode
  localparam logic [2:0] MODE_ADD       = 3'd0;
  localparam logic [2:0] MODE_SUB       = 3'd1;
  localparam logic [2:0] MODE_MATMUL    = 3'd2;
  localparam logic [2:0] MODE_SCALE     = 3'd3;
  localparam logic [2:0] MODE_TRANSPOSE = 3'd4;

  // register indexes on the configuration port
  localparam logic REG_OP_MODE = 1'b0;
  localparam logic REG_SCALE   = 1'b1;

  // reset values of the registers
  localparam logic [2:0]             OP_MODE_RESET = MODE_MATMUL;
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET   = 32'h0001_0000;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_lo;  // multiply by the low half of the right operand
    logic mul_hi;  // multiply by the high half of the right operand
  } mac_ctrl_t;

endpackage

[rtl/mx4au_ram.sv]
// matrix element store: one write port, one read port, registered read data
module mx4au_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mx4au_mac.sv]
// multiply-accumulate unit: half-width partial products, exact floor shift, saturation
module mx4au_mac #(
  parameter int DATA_WIDTH = 32,
  parameter int B_WIDTH    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mx4au_pkg::mac_ctrl_t         ctrl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [B_WIDTH-1:0]    b,
  output logic [DATA_WIDTH-1:0]        result
);

  localparam int LO = B_WIDTH / 2;
  localparam int HI = B_WIDTH - LO;
  localparam int PW = DATA_WIDTH + HI + 1;
  localparam int AW = DATA_WIDTH + B_WIDTH + 4;

  localparam logic signed [AW-1:0] MAXV = {{(AW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] MINV = ~MAXV;

  logic signed [LO:0]     b_lo;
  logic signed [HI-1:0]   b_hi;
  logic signed [HI:0]     mop;
  logic signed [PW-1:0]   prod_next;
  logic signed [PW-1:0]   prod;
  logic                   pend_valid;
  logic                   pend_hi;
  logic signed [AW-1:0]   addend;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   shifted;

  assign b_lo      = {1'b0, b[LO-1:0]};
  assign b_hi      = b[B_WIDTH-1:LO];
  assign mop       = ctrl.mul_hi ? (HI + 1)'(b_hi) : (HI + 1)'(b_lo);
  assign prod_next = a * mop;
  assign addend    = pend_hi ? (AW'(prod) <<< LO) : AW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_hi    <= 1'b0;
    end else if (ctrl.clear) begin
      pend_valid <= 1'b0;
      pend_hi    <= 1'b0;
    end else begin
      pend_valid <= ctrl.mul_lo | ctrl.mul_hi;
      pend_hi    <= ctrl.mul_hi;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pend_valid) begin
      acc <= acc + addend;
    end
  end

  // arithmetic shift gives the floor of the exact sum
  assign shifted = acc >>> mx4au_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > MAXV) begin
      result = MAXV[DATA_WIDTH-1:0];
    end else if (shifted < MINV) begin
      result = MINV[DATA_WIDTH-1:0];
    end else begin
      result = shifted[DATA_WIDTH-1:0];
    end
  end

endmodule

[rtl/matrix4x4_arith_unit.sv]
// top level of the matrix arithmetic unit: config registers, sequencer, element stores
//
// usage
//   input channel (in_valid, in_stall, a_value, b_value): one request carries one
//   row-major element of A and of B. DIM*DIM requests make up one job.
//   output channel (out_valid, out_stall, value, row_index, col_index, last): after
//   the final pair of a job the unit emits DIM*DIM result elements in row-major
//   order, last marks the final one.
//   config port (APB): op_mode at address 0, scale_factor at address 4.
// timing
//   loading takes one request per cycle while the sequencer is parked. per result
//   element the sequencer steps through read and done for add, subtract,
//   transpose and unused codes, adds a low pass, a high pass and a drain for
//   scale, and for matrix multiply a low and a high pass per inner term and the
//   drain: the single multiply-accumulate unit runs each product as two half-width
//   passes, and each element store has one read port.
// reset and stall
//   reset clears the load count, the sequencer and out_valid, and sets op_mode to
//   matrix multiply and scale_factor to 1.0. the stores are not cleared.
//   a stalled result holds in the output register, the sequencer waits behind it;
//   a new job is taken in while the final result still waits.
module matrix4x4_arith_unit #(
  parameter int DIM        = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DATA_WIDTH-1:0]         a_value,
  input  logic [DATA_WIDTH-1:0]         b_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [DATA_WIDTH-1:0]         value,
  output logic [$clog2(DIM)-1:0]        row_index,
  output logic [$clog2(DIM)-1:0]        col_index,
  output logic                          last,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CELLS = DIM * DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int IW    = $clog2(DIM);
  localparam int SW    = mx4au_pkg::SCALE_WIDTH;
  localparam int BW    = (DATA_WIDTH > SW) ? DATA_WIDTH : SW;

  localparam logic [CW-1:0] LAST_SLOT = CW'(CELLS - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(DIM - 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_LO,
    S_HI,
    S_DRAIN,
    S_DONE
  } state_t;

  // config registers
  logic [2:0]           op_mode;
  logic signed [SW-1:0] scale_factor;
  logic                 cfg_write;

  // sequencer
  state_t               state;
  logic [CW-1:0]        load_count;
  logic [IW-1:0]        row;
  logic [IW-1:0]        col;
  logic [IW-1:0]        kk;
  logic [IW-1:0]        rd_k;
  logic                 is_matmul;
  logic                 uses_mac;
  logic                 out_free;
  logic                 in_take;

  // store ports
  logic                  mem_we;
  logic                  mem_re;
  logic [CW-1:0]         l_raddr;
  logic [CW-1:0]         r_raddr;
  logic [DATA_WIDTH-1:0] l_rdata;
  logic [DATA_WIDTH-1:0] r_rdata;

  // datapath
  mx4au_pkg::mac_ctrl_t     mac_ctrl;
  logic signed [BW-1:0]     mac_b;
  logic [DATA_WIDTH-1:0]    mac_result;
  logic signed [DATA_WIDTH:0] sum;
  logic [DATA_WIDTH-1:0]    simple_result;
  logic [DATA_WIDTH-1:0]    elem_result;

  // config port, always ready, reads are combinational
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= mx4au_pkg::OP_MODE_RESET;
      scale_factor <= mx4au_pkg::SCALE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        mx4au_pkg::REG_OP_MODE: op_mode      <= pwdata[2:0];
        mx4au_pkg::REG_SCALE:   scale_factor <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mx4au_pkg::REG_OP_MODE: prdata = {29'd0, op_mode};
      mx4au_pkg::REG_SCALE:   prdata = scale_factor;
      default:                prdata = '0;
    endcase
  end

  assign is_matmul = (op_mode == mx4au_pkg::MODE_MATMUL);
  assign uses_mac  = is_matmul || (op_mode == mx4au_pkg::MODE_SCALE);
  assign out_free  = !out_valid || !out_stall;

  // loading only while the sequencer is parked
  assign in_stall = (state != S_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign mem_we   = in_take;

  // inner index of the read: first term on entry, next term during the high pass
  assign rd_k   = (state == S_HI) ? IW'(kk + 1'b1) : '0;
  assign mem_re = (state == S_READ) || (state == S_HI && is_matmul && kk != LAST_IDX);

  always_comb begin
    if (is_matmul) begin
      l_raddr = CW'(int'(row) * DIM + int'(rd_k));
      r_raddr = CW'(int'(rd_k) * DIM + int'(col));
    end else if (op_mode == mx4au_pkg::MODE_TRANSPOSE) begin
      l_raddr = CW'(int'(col) * DIM + int'(row));
      r_raddr = CW'(int'(row) * DIM + int'(col));
    end else begin
      l_raddr = CW'(int'(row) * DIM + int'(col));
      r_raddr = CW'(int'(row) * DIM + int'(col));
    end
  end

  mx4au_ram #(
    .DEPTH (CELLS),
    .WIDTH (DATA_WIDTH)
  ) u_left_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_count),
    .wdata (a_value),
    .re    (mem_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  mx4au_ram #(
    .DEPTH (CELLS),
    .WIDTH (DATA_WIDTH)
  ) u_right_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_count),
    .wdata (b_value),
    .re    (mem_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // right operand is the stored element or the scalar, both sign extended
  assign mac_b = (op_mode == mx4au_pkg::MODE_SCALE) ? BW'(scale_factor)
                                                    : BW'($signed(r_rdata));

  assign mac_ctrl.clear  = (state == S_READ);
  assign mac_ctrl.mul_lo = (state == S_LO);
  assign mac_ctrl.mul_hi = (state == S_HI);

  mx4au_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .B_WIDTH    (BW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a      ($signed(l_rdata)),
    .b      (mac_b),
    .result (mac_result)
  );

  // elementwise modes, read data is steady in the done state
  always_comb begin
    if (op_mode == mx4au_pkg::MODE_SUB) begin
      sum = $signed(l_rdata) - $signed(r_rdata);
    end else begin
      sum = $signed(l_rdata) + $signed(r_rdata);
    end
  end

  always_comb begin
    case (op_mode) inside
      mx4au_pkg::MODE_ADD, mx4au_pkg::MODE_SUB: begin
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
          simple_result = {sum[DATA_WIDTH], {(DATA_WIDTH - 1){~sum[DATA_WIDTH]}}};
        end else begin
          simple_result = sum[DATA_WIDTH-1:0];
        end
      end
      mx4au_pkg::MODE_TRANSPOSE: simple_result = l_rdata;
      default:                   simple_result = '0;
    endcase
  end

  assign elem_result = uses_mac ? mac_result : simple_result;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      kk         <= '0;
      out_valid  <= 1'b0;
    end else begin
      // the done state sets or holds out_valid itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (load_count == LAST_SLOT) begin
              load_count <= '0;
              row        <= '0;
              col        <= '0;
              state      <= S_READ;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_READ: begin
          kk    <= '0;
          state <= uses_mac ? S_LO : S_DONE;
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          if (is_matmul && kk != LAST_IDX) begin
            kk    <= kk + 1'b1;
            state <= S_LO;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= elem_result;
            row_index <= row;
            col_index <= col;
            last      <= (row == LAST_IDX) && (col == LAST_IDX);
            if (col == LAST_IDX) begin
              col <= '0;
              if (row == LAST_IDX) begin
                row   <= '0;
                state <= S_LOAD;
              end else begin
                row   <= row + 1'b1;
                state <= S_READ;
              end
            end else begin
              col   <= col + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

[verif/tb_matrix4x4_arith_unit.sv]
// testbench of the 4x4 matrix arithmetic unit: random jobs, per-element prediction and check
module tb_matrix4x4_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // codes that the unit does not define, their results read as zero
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int CELLS       = 16;
  localparam int CYCLE_LIMIT = 200000;
  // long receiver hold-off that makes the unit back up into its input
  localparam int LONG_HOLD   = 400;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } pair_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } elem_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] a_value = '0;
  logic [31:0] b_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic [1:0]  row_index;
  logic [1:0]  col_index;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  matrix4x4_arith_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_value   (a_value),
    .b_value   (b_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .row_index (row_index),
    .col_index (col_index),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // requests waiting to go out, and results the unit still owes
  pair_t pending_pairs[$];
  elem_t owed_elems[$];

  // register copies, only changed while the unit is idle
  logic [2:0]         cur_mode  = mx4au_pkg::OP_MODE_RESET;
  logic signed [31:0] cur_scale = mx4au_pkg::SCALE_RESET;

  // matrices as loaded so far in the current job
  logic signed [31:0] left_cells[CELLS];
  logic signed [31:0] right_cells[CELLS];
  int                 fill_count = 0;

  int queued_total   = 0;
  int accepted_total = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  bit calm           = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, owed_elems.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // clamp to the signed 32-bit range
  function automatic logic [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return Q_MAX;
    if (v < -80'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  // one element of the result, row r column c, under the current registers
  function automatic logic [31:0] element_of(input int r, input int c);
    logic signed [79:0] acc;
    longint             prod;
    int                 idx;
    idx = r * 4 + c;
    acc = '0;
    case (cur_mode)
      mx4au_pkg::MODE_ADD: begin
        acc = longint'(left_cells[idx]) + longint'(right_cells[idx]);
      end
      mx4au_pkg::MODE_SUB: begin
        acc = longint'(left_cells[idx]) - longint'(right_cells[idx]);
      end
      mx4au_pkg::MODE_MATMUL: begin
        // full-precision sum of products, then floor on the shift
        for (int k = 0; k < 4; k++) begin
          prod = longint'(left_cells[r * 4 + k]) * longint'(right_cells[k * 4 + c]);
          acc  = acc + prod;
        end
        acc = acc >>> mx4au_pkg::FRAC_BITS;
      end
      mx4au_pkg::MODE_SCALE: begin
        prod = longint'(left_cells[idx]) * longint'(cur_scale);
        acc  = prod;
        acc  = acc >>> mx4au_pkg::FRAC_BITS;
      end
      mx4au_pkg::MODE_TRANSPOSE: begin
        acc = longint'(left_cells[c * 4 + r]);
      end
      default: begin
        acc = '0;
      end
    endcase
    return clamp32(acc);
  endfunction

  // store one accepted pair; the sixteenth releases a whole result
  task automatic take_pair(input logic [31:0] a, input logic [31:0] b);
    elem_t e;
    left_cells[fill_count]  = a;
    right_cells[fill_count] = b;
    accepted_total++;
    if (fill_count == CELLS - 1) begin
      fill_count = 0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          e.value = element_of(r, c);
          e.row   = r[1:0];
          e.col   = c[1:0];
          e.last  = (r == 3 && c == 3);
          owed_elems.push_back(e);
        end
      end
    end else begin
      fill_count++;
    end
  endtask

  // sender: holds a request until taken, random idle bursts between requests
  int    gap_left = 0;
  pair_t next_pair;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_pair(a_value, b_value);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          next_pair = pending_pairs.pop_front();
          a_value  <= next_pair.a;
          b_value  <= next_pair.b;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver: checks every accepted element, stalls in bursts, holds off once for long
  int    stall_left = 0;
  int    hold_left  = 0;
  bit    held_once  = 1'b0;
  elem_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_elems.size() == 0) begin
          $display("%0t: unexpected result value=%h row=%0d col=%0d last=%b",
                   $realtime, value, row_index, col_index, last);
          error_count++;
        end else begin
          want = owed_elems.pop_front();
          if (value !== want.value) begin
            $display("%0t: value mismatch expected %h actual %h", $realtime, want.value, value);
            error_count++;
          end
          if (row_index !== want.row) begin
            $display("%0t: row_index mismatch expected %0d actual %0d",
                     $realtime, want.row, row_index);
            error_count++;
          end
          if (col_index !== want.col) begin
            $display("%0t: col_index mismatch expected %0d actual %0d",
                     $realtime, want.col, col_index);
            error_count++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch expected %b actual %b", $realtime, want.last, last);
            error_count++;
          end
        end
      end
      // once the first job is through: stop taking results while the sender keeps going
      if (!held_once && results_seen == 16) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // apb write: setup cycle, access cycle, register taken at the edge with pready
  task automatic reg_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == mx4au_pkg::REG_OP_MODE) begin
      cur_mode = data[2:0];
    end else begin
      cur_scale = data;
    end
  endtask

  // every queued request taken and every owed result seen, then a short drain
  task automatic wait_drained(input int tail);
    while (accepted_total != queued_total || owed_elems.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // operand mix: full-range noise, small values so products stay in range, and extremes
  function automatic logic [31:0] pick_operand();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom();
    end else if (sel < 8) begin
      v = $urandom_range(0, 524288);
      v = v - 32'd262144;
    end else begin
      case ($urandom_range(0, 6))
        0: v = Q_MAX;
        1: v = Q_MIN;
        2: v = '0;
        3: v = Q_ONE;
        4: v = -Q_ONE;
        5: v = 32'd1;
        default: v = 32'hffff_ffff;
      endcase
    end
    return v;
  endfunction

  task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    pending_pairs.push_back(p);
    queued_total++;
  endtask

  // directed job: field extremes against the reset registers (multiply, scale 1.0)
  logic [31:0] edge_a[CELLS] = '{Q_MAX, Q_MIN, 32'd0, Q_ONE, -Q_ONE, 32'd1, 32'hffff_ffff, Q_MAX,
                                 Q_MIN, Q_ONE, 32'd0, Q_MAX, 32'h0000_8000, Q_MIN, 32'd2, Q_MAX};
  logic [31:0] edge_b[CELLS] = '{Q_MAX, Q_MAX, Q_MIN, -Q_ONE, Q_ONE, 32'hffff_ffff, 32'd1, Q_MIN,
                                 Q_MIN, 32'd0, Q_ONE, Q_MAX, 32'hffff_8000, Q_ONE, Q_MIN, Q_MAX};

  // phase plan: mode, scalar, jobs; spare codes and the scalar extremes included
  localparam int PHASES = 13;
  logic [2:0]  plan_mode[PHASES] = '{mx4au_pkg::MODE_ADD, mx4au_pkg::MODE_SUB,
                                     mx4au_pkg::MODE_SCALE, mx4au_pkg::MODE_SCALE,
                                     mx4au_pkg::MODE_SCALE, mx4au_pkg::MODE_SCALE,
                                     mx4au_pkg::MODE_TRANSPOSE, MODE_SPARE5, MODE_SPARE6,
                                     MODE_SPARE7, mx4au_pkg::MODE_MATMUL,
                                     mx4au_pkg::MODE_MATMUL, mx4au_pkg::MODE_ADD};
  int          plan_jobs[PHASES] = '{3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
  logic [31:0] scalar;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < CELLS; i++) begin
      queue_pair(edge_a[i], edge_b[i]);
    end
    wait_drained(8);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        2: scalar = Q_MAX;
        3: scalar = Q_MIN;
        4: scalar = '0;
        default: scalar = $urandom();
      endcase
      reg_write(mx4au_pkg::REG_OP_MODE, {29'd0, plan_mode[ph]});
      reg_write(mx4au_pkg::REG_SCALE, scalar);
      // the final phases run without idling on either side
      if (ph >= PHASES - 2) calm = 1'b1;
      for (int j = 0; j < plan_jobs[ph] * CELLS; j++) begin
        queue_pair(pick_operand(), pick_operand());
      end
      wait_drained(8);
    end

    wait_drained(40);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[matrix4x4_arith_unit.f]
rtl/mx4au_pkg.sv
rtl/mx4au_ram.sv
rtl/mx4au_mac.sv
rtl/matrix4x4_arith_unit.sv
verif/tb_matrix4x4_arith_unit.sv
